/* design/mlfd_pkg.sv */
package mlfd_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 524288;
    localparam logic [31:0] FRAME_CAP = 32'(MAX_FRAME_BYTES - 4);

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_PATTERN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_LEN = 1'd1;

    localparam logic [31:0] MAGIC_RESET = 32'h55AA_55AA;
    localparam logic [18:0] MAX_BODY_LEN_RESET = 19'd524284;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_SYNC = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_ABORT  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [18:0] body_offset;
        logic [31:0] declared_len;
        logic        frame_last;
    } result_t;

endpackage

/* design/mlfd_front.sv */
module mlfd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mlfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  logic [7:0]                          rx_byte,
    output logic                                push,
    output mlfd_pkg::result_t                   push_data
);
    import mlfd_pkg::*;

    logic [31:0] magic_pattern_reg;
    logic [18:0] max_body_len_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] sync_window_reg, sync_window_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [18:0] body_count_reg, body_count_next;

    logic [31:0] shifted_window;
    logic [31:0] assembled_len;
    logic [31:0] length_limit;
    logic        body_done;

    assign shifted_window = {rx_byte, sync_window_reg[31:8]};
    assign assembled_len = length_accum_reg | ({24'd0, rx_byte} << {header_count_reg, 3'd0});
    assign length_limit = ({13'd0, max_body_len_reg} < FRAME_CAP)
                        ? {13'd0, max_body_len_reg} : FRAME_CAP;
    assign body_done = (({13'd0, body_count_reg} + 32'd1) >= length_accum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_pattern_reg <= MAGIC_RESET;
            max_body_len_reg <= MAX_BODY_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAGIC_PATTERN: magic_pattern_reg <= cfg_data;
                REG_MAX_BODY_LEN:  max_body_len_reg <= cfg_data[18:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        sync_window_next = sync_window_reg;
        header_count_next = header_count_reg;
        length_accum_next = length_accum_reg;
        body_count_next = body_count_reg;
        push = 1'b0;
        push_data = '{kind: KIND_HEADER, data_byte: 8'd0, body_offset: 19'd0,
                      declared_len: 32'd0, frame_last: 1'b0};
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    length_accum_next = assembled_len;
                    header_count_next = header_count_reg + 2'd1;
                    if (header_count_reg == 2'd3)
                    begin
                        push = 1'b1;
                        push_data.declared_len = assembled_len;
                        if (assembled_len > length_limit)
                        begin
                            push_data.kind = KIND_REJECT;
                            sync_window_next = 32'd0;
                            phase_next = PH_SYNC;
                        end
                        else if (assembled_len == 32'd0)
                        begin
                            push_data.frame_last = 1'b1;
                            sync_window_next = 32'd0;
                            phase_next = PH_SYNC;
                        end
                        else
                        begin
                            body_count_next = 19'd0;
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    push = 1'b1;
                    push_data.body_offset = body_count_reg;
                    if (shifted_window == magic_pattern_reg)
                    begin
                        push_data.kind = KIND_ABORT;
                        sync_window_next = 32'd0;
                        header_count_next = 2'd0;
                        length_accum_next = 32'd0;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        push_data.kind = KIND_BODY;
                        push_data.data_byte = rx_byte;
                        push_data.frame_last = body_done;
                        body_count_next = body_count_reg + 19'd1;
                        if (body_done)
                        begin
                            sync_window_next = 32'd0;
                            phase_next = PH_SYNC;
                        end
                        else
                        begin
                            sync_window_next = shifted_window;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC;
                    sync_window_next = shifted_window;
                    if (shifted_window == magic_pattern_reg)
                    begin
                        phase_next = PH_LEN;
                        header_count_next = 2'd0;
                        length_accum_next = 32'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC;
            sync_window_reg <= 32'd0;
            header_count_reg <= 2'd0;
            length_accum_reg <= 32'd0;
            body_count_reg <= 19'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            sync_window_reg <= sync_window_next;
            header_count_reg <= header_count_next;
            length_accum_reg <= length_accum_next;
            body_count_reg <= body_count_next;
        end
    end

    a_count_only_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        (header_count_reg != 2'd0) |-> (phase_reg == PH_LEN))
        else $error("Header byte count is nonzero outside the length phase.");

    a_body_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (length_accum_reg != 32'd0))
        else $error("Body phase entered with a zero length.");

    a_body_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> ({13'd0, body_count_reg} < length_accum_reg))
        else $error("Body offset reached the declared length without ending the frame.");

endmodule

/* design/mlfd_queue.sv */
module mlfd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mlfd_pkg::result_t  push_data,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output mlfd_pkg::result_t  head
);
    import mlfd_pkg::*;

    result_t                entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("Result written into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("Result taken from an empty queue.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Queue occupancy exceeds its depth.");

endmodule

/* design/mlfd_back.sv */
module mlfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               not_empty,
    input  mlfd_pkg::result_t  head,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output mlfd_pkg::result_t  out_data
);
    import mlfd_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;

    assign pop = not_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("Output register reloaded while its transaction is stalled.");

    a_drain_without_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !not_empty) |=> !out_valid_reg)
        else $error("Output stayed valid after its transaction with no result queued.");

    a_pending_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && not_empty) |=> out_valid_reg)
        else $error("Queued result not moved into an empty output register.");

endmodule

/* design/magic_length_frame_deframer_top.sv */
// Each result is written into the result queue and then loaded into the output
// register. Throughput: one byte per cycle while the result queue is not full.
// Each byte is classified in a single front-end update.
// A two-entry result queue and an output register let input and output stall apart.
// Reset is asynchronous and active low: search phase, empty window, configuration
// registers at their reset values, queue and output register empty.
module magic_length_frame_deframer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mlfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          kind,
    output logic [7:0]                          data_byte,
    output logic [18:0]                         body_offset,
    output logic [31:0]                         declared_len,
    output logic                                frame_last
);
    import mlfd_pkg::*;

    logic    accept;
    logic    push;
    result_t push_data;
    logic    pop;
    logic    full;
    logic    not_empty;
    result_t head;
    result_t out_data;

    assign in_stall = full;
    assign accept = in_valid && !full;

    mlfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_data (push_data)
    );

    mlfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    mlfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign kind = out_data.kind;
    assign data_byte = out_data.data_byte;
    assign body_offset = out_data.body_offset;
    assign declared_len = out_data.declared_len;
    assign frame_last = out_data.frame_last;

endmodule

/* test/magic_length_frame_deframer_top_test.sv */
`timescale 1ns / 100ps

module magic_length_frame_deframer_top_test;

    import mlfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MAGIC_PATTERN;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             rx_byte = 8'h00;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    logic [1:0]             kind;
    logic [7:0]             data_byte;
    logic [18:0]            body_offset;
    logic [31:0]            declared_len;
    logic                   frame_last;

    magic_length_frame_deframer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .body_offset  (body_offset),
        .declared_len (declared_len),
        .frame_last   (frame_last)
    );

    always #5 clk = ~clk;

    // Deframer state as the block should hold it.
    phase_t      sync_phase = PH_SYNC;
    logic [31:0] sync_window = '0;
    logic [1:0]  length_bytes_seen = '0;
    logic [31:0] frame_length = '0;
    logic [18:0] body_bytes_seen = '0;
    logic [31:0] active_magic = MAGIC_RESET;
    logic [18:0] active_max_len = MAX_BODY_LEN_RESET;

    result_t     frame_results[$];
    logic [7:0]  link_bytes[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 30;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    logic        in_taken = 1'b0;
    logic        hold_off = 1'b0;

    logic [31:0] cur_magic = MAGIC_RESET;
    logic [31:0] cur_limit = 32'(MAX_BODY_LEN_RESET);

    function automatic int unsigned pick_gap();
        int unsigned gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) begin
            if ($urandom_range(0, 9) < 7) begin
                gap = $urandom_range(1, 3);
            end
            else begin
                gap = $urandom_range(8, 40);
            end
        end
        return gap;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic advance_deframer(input logic [7:0] b);
        result_t     res;
        logic [31:0] limit;
        logic        is_last;
        res = '0;
        limit = (32'(active_max_len) < FRAME_CAP) ? 32'(active_max_len) : FRAME_CAP;
        case (sync_phase)
            PH_LEN:
            begin
                frame_length = frame_length | (32'(b) << (8 * length_bytes_seen));
                length_bytes_seen = length_bytes_seen + 2'd1;
                if (length_bytes_seen == 2'd0) begin
                    res.declared_len = frame_length;
                    if (frame_length > limit) begin
                        res.kind = KIND_REJECT;
                        sync_window = '0;
                        sync_phase = PH_SYNC;
                    end
                    else if (frame_length == 32'd0) begin
                        res.kind = KIND_HEADER;
                        res.frame_last = 1'b1;
                        sync_window = '0;
                        sync_phase = PH_SYNC;
                    end
                    else begin
                        res.kind = KIND_HEADER;
                        body_bytes_seen = '0;
                        sync_phase = PH_BODY;
                    end
                    frame_results.push_back(res);
                end
            end
            PH_BODY:
            begin
                sync_window = {b, sync_window[31:8]};
                res.body_offset = body_bytes_seen;
                if (sync_window == active_magic) begin
                    res.kind = KIND_ABORT;
                    sync_window = '0;
                    length_bytes_seen = '0;
                    frame_length = '0;
                    sync_phase = PH_LEN;
                end
                else begin
                    is_last = ({13'd0, body_bytes_seen} + 32'd1) >= frame_length;
                    res.kind = KIND_BODY;
                    res.data_byte = b;
                    res.frame_last = is_last;
                    body_bytes_seen = body_bytes_seen + 19'd1;
                    if (is_last) begin
                        sync_window = '0;
                        sync_phase = PH_SYNC;
                    end
                end
                frame_results.push_back(res);
            end
            default:
            begin
                sync_phase = PH_SYNC;
                sync_window = {b, sync_window[31:8]};
                if (sync_window == active_magic) begin
                    sync_phase = PH_LEN;
                    length_bytes_seen = '0;
                    frame_length = '0;
                end
            end
        endcase
    endtask

    task automatic check_result();
        result_t want;
        if (frame_results.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, kind %0d", kind));
        end
        else begin
            want = frame_results.pop_front();
            if (kind !== want.kind) begin
                report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
            end
            if (data_byte !== want.data_byte) begin
                report_mismatch($sformatf("data_byte %0h, expected %0h",
                                          data_byte, want.data_byte));
            end
            if (body_offset !== want.body_offset) begin
                report_mismatch($sformatf("body_offset %0d, expected %0d",
                                          body_offset, want.body_offset));
            end
            if (declared_len !== want.declared_len) begin
                report_mismatch($sformatf("declared_len %0h, expected %0h",
                                          declared_len, want.declared_len));
            end
            if (frame_last !== want.frame_last) begin
                report_mismatch($sformatf("frame_last %0b, expected %0b",
                                          frame_last, want.frame_last));
            end
        end
    endtask

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_MAGIC_PATTERN: active_magic = cfg_data;
                    REG_MAX_BODY_LEN:  active_max_len = cfg_data[18:0];
                endcase
            end
            if (out_valid && !out_stall) begin
                check_result();
            end
            in_taken = in_valid && !in_stall;
            if (in_taken) begin
                advance_deframer(rx_byte);
                bytes_accepted++;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (link_bytes.size() != 0) begin
                in_valid <= 1'b1;
                rx_byte <= link_bytes.pop_front();
                send_gap = pick_gap();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            out_stall <= hold_off || (stall_left != 0);
            if (stall_left != 0) begin
                stall_left--;
            end
            else begin
                stall_left = pick_gap();
            end
        end
    end

    // Long receiver hold-off so that the result queue fills and the input stalls.
    initial begin
        wait (bytes_accepted >= 120);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_word(input logic [31:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
        send_byte(w[23:16]);
        send_byte(w[31:24]);
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned cut;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
        else begin
            send_word(cur_magic);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(0, 12);
            end
            else if (pick < 85 && cur_limit <= 32'd40) begin
                len = cur_limit + 32'($urandom_range(0, 1));
            end
            else begin
                len = $urandom;
            end
            send_word(len);
            if (len <= cur_limit && len <= 32'd64) begin
                if (len > 32'd5 && $urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(0, len - 5);
                    repeat (cut) send_byte(8'($urandom));
                    send_word(cur_magic);
                    len = $urandom_range(0, 8);
                    send_word(len);
                    if (len <= cur_limit) begin
                        repeat (len) send_byte(8'($urandom));
                    end
                end
                else begin
                    repeat (len) send_byte(8'($urandom));
                end
            end
        end
    endtask

    task automatic send_random_bytes(input int unsigned count);
        int unsigned start;
        start = bytes_queued;
        while (bytes_queued - start < count) begin
            send_random_frame();
        end
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || frame_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic program_regs(input logic [31:0] magic, input logic [31:0] limit_word);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAGIC_PATTERN;
        cfg_data <= magic;
        @(negedge clk);
        cfg_index <= REG_MAX_BODY_LEN;
        cfg_data <= limit_word;
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_magic = magic;
        cur_limit = (32'(limit_word[18:0]) < FRAME_CAP) ? 32'(limit_word[18:0]) : FRAME_CAP;
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: empty frame, rejected length, resync abort.
        send_byte(8'h00);
        send_word(MAGIC_RESET);
        send_word(32'd0);
        send_word(MAGIC_RESET);
        send_word(32'hFFFF_FFFF);
        send_word(MAGIC_RESET);
        send_word(32'd3);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_word(32'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();

        // All-ones magic, zero length limit with upper data bits set.
        program_regs(32'hFFFF_FFFF, 32'hFFF8_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'd1);
        send_random_bytes(50);
        wait_idle();

        // Small limit: lengths at the limit and one past it.
        program_regs($urandom, {13'h1555, 19'd3});
        send_word(cur_magic);
        send_word(32'd3);
        repeat (3) send_byte(8'($urandom));
        send_word(cur_magic);
        send_word(32'd4);
        send_random_bytes(50);
        wait_idle();

        // Zero magic, limit above the frame cap.
        program_regs(32'h0000_0000, 32'h0007_FFFF);
        send_word(32'h0000_0000);
        send_word(FRAME_CAP);
        send_byte(8'h12);
        send_byte(8'h00);
        send_word(FRAME_CAP + 32'd1);
        send_random_bytes(30);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            idle_pct = (p == 1) ? 0 : (p == 3) ? 70 : 30;
            program_regs($urandom,
                         ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 24)));
            send_random_bytes(30);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
